[src/dnss_pkg.sv]
// Package for the directional nearest-site search block.
// Holds sizes, op, direction and status codes, and the controller/datapath command types.
package dnss_pkg;
   localparam int MAX_SITES  = 256;
   localparam int MAX_ZONES  = 8;
   localparam int COORD_BITS = 16;
   localparam int SIDX_BITS  = $clog2(MAX_SITES);
   localparam int ZIDX_BITS  = $clog2(MAX_ZONES);
   localparam int SCNT_BITS  = SIDX_BITS + 1;
   localparam int ZCNT_BITS  = ZIDX_BITS + 1;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int SQ_BITS    = 2 * DIFF_BITS + 1;

   localparam logic [1:0] OP_LOAD_SITE = 2'd0;
   localparam logic [1:0] OP_LOAD_ZONE = 2'd1;
   localparam logic [1:0] OP_QUERY     = 2'd2;

   localparam logic [2:0] DIR_LEFT      = 3'd0;
   localparam logic [2:0] DIR_RIGHT     = 3'd1;
   localparam logic [2:0] DIR_UP        = 3'd2;
   localparam logic [2:0] DIR_DOWN      = 3'd3;
   localparam logic [2:0] DIR_UPRIGHT   = 3'd4;
   localparam logic [2:0] DIR_UPLEFT    = 3'd5;
   localparam logic [2:0] DIR_DOWNLEFT  = 3'd6;
   localparam logic [2:0] DIR_DOWNRIGHT = 3'd7;

   localparam logic [1:0] ST_FOUND   = 2'd0;
   localparam logic [1:0] ST_NO_ZONE = 2'd1;
   localparam logic [1:0] ST_NO_SITE = 2'd2;

   localparam logic CSR_SITE_COUNT = 1'b0;
   localparam logic CSR_ZONE_COUNT = 1'b1;

   typedef struct packed {
      logic capture;    // latch query point and flags
      logic zone_step;  // test one zone for the point
      logic site_read;  // issue a site table read
      logic site_eval;  // evaluate the registered site
      logic szone_step; // test one zone for the site
      logic clear;      // clear the site zone search
   } dp_cmd_type;

   typedef struct packed {
      logic pt_zone_hit;
      logic site_zone_hit;
      logic same_zone;  // captured same-zone flag of the current query
   } dp_sts_type;
endpackage

[src/dnss_if.sv]
// Valid/ready channel interfaces for the search block.
// Depends on dnss_pkg for field widths.
interface dnss_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [1:0]                             op;
   logic [7:0]                             entry_index;
   logic signed [dnss_pkg::COORD_BITS-1:0] coord_x;
   logic signed [dnss_pkg::COORD_BITS-1:0] coord_y;
   logic signed [dnss_pkg::COORD_BITS-1:0] bound_x;
   logic signed [dnss_pkg::COORD_BITS-1:0] bound_y;
   logic [2:0]                             direction;
   logic                                   strict;
   logic                                   same_zone;
   modport source (output valid, op, entry_index, coord_x, coord_y, bound_x, bound_y,
                   direction, strict, same_zone, input ready);
   modport sink (input valid, op, entry_index, coord_x, coord_y, bound_x, bound_y,
                 direction, strict, same_zone, output ready);
endinterface

interface dnss_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] site_index;
   logic [1:0] status;
   modport source (output valid, site_index, status, input ready);
   modport sink (input valid, site_index, status, output ready);
endinterface

interface dnss_csr_if;
   logic       valid;
   logic       ready;
   logic       index;
   logic [8:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[src/directional_nearest_site_search.sv]
// Directional nearest-site search, top level.
// Loads write the tables when accepted. A query searches the zones for the point, then
// reads and evaluates each site in turn via the single site table port, searching zones per
// site under same-zone filtering; the result holds until taken. One query at a time.
// Synchronous reset clears counts and control; tables are undefined until loaded.
module directional_nearest_site_search (
   input logic     clock,
   input logic     reset,
   dnss_req_if.sink   req,
   dnss_rsp_if.source rsp,
   dnss_csr_if.sink   csr
);
   import dnss_pkg::*;

   logic [SCNT_BITS-1:0] scount_ff;
   logic [ZCNT_BITS-1:0] zcount_ff;
   dp_cmd_type           cmd;
   dp_sts_type           sts;
   logic [SIDX_BITS-1:0] site_addr, best;
   logic [ZIDX_BITS-1:0] zone_addr;
   logic                 busy, done, no_zone, found, acc, start;

   assign req.ready = !busy;
   assign csr.ready = 1'b1;
   assign acc   = req.valid && req.ready;
   assign start = acc && req.op == OP_QUERY;

   always_ff @(posedge clock) begin
      if (reset) begin
         scount_ff <= '0;
         zcount_ff <= '0;
      end else if (csr.valid) begin
         unique case (csr.index)
            CSR_SITE_COUNT: scount_ff <= csr.data;
            default:        zcount_ff <= csr.data[ZCNT_BITS-1:0];
         endcase
      end
   end

   dnss_ctrl u_ctrl (
      .clock, .reset, .start,
      .site_count(scount_ff), .zone_count(zcount_ff), .sts,
      .rsp_taken(rsp.ready), .cmd, .site_addr, .zone_addr, .busy, .done, .no_zone
   );

   dnss_datapath u_dp (
      .clock,
      .site_we(acc && req.op == OP_LOAD_SITE),
      .zone_we(acc && req.op == OP_LOAD_ZONE && req.entry_index < 8'(MAX_ZONES)),
      .wr_site(req.entry_index), .wr_zone(req.entry_index[ZIDX_BITS-1:0]),
      .in_x(req.coord_x), .in_y(req.coord_y), .in_bx(req.bound_x), .in_by(req.bound_y),
      .in_dir(req.direction), .in_strict(req.strict), .in_same(req.same_zone),
      .cmd, .site_addr, .zone_addr, .sts, .found, .best
   );

   assign rsp.valid      = done;
   assign rsp.status     = no_zone ? ST_NO_ZONE : (found ? ST_FOUND : ST_NO_SITE);
   assign rsp.site_index = (!no_zone && found) ? best : '0;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req.ready) else $error("input taken while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status))
      else $error("result dropped");
   a_start: assert property (@(posedge clock) disable iff (reset)
      start |=> busy) else $error("query not started");
endmodule

[src/dnss_datapath.sv]
// Datapath: site and zone tables, zone tests, match logic and best-site tracking.
// Depends on dnss_pkg; driven by dnss_ctrl through command signals.
module dnss_datapath (
   input  logic                                   clock,
   input  logic                                   site_we,
   input  logic                                   zone_we,
   input  logic [dnss_pkg::SIDX_BITS-1:0]         wr_site,
   input  logic [dnss_pkg::ZIDX_BITS-1:0]         wr_zone,
   input  logic signed [dnss_pkg::COORD_BITS-1:0] in_x,
   input  logic signed [dnss_pkg::COORD_BITS-1:0] in_y,
   input  logic signed [dnss_pkg::COORD_BITS-1:0] in_bx,
   input  logic signed [dnss_pkg::COORD_BITS-1:0] in_by,
   input  logic [2:0]                             in_dir,
   input  logic                                   in_strict,
   input  logic                                   in_same,
   input  dnss_pkg::dp_cmd_type                   cmd,
   input  logic [dnss_pkg::SIDX_BITS-1:0]         site_addr,
   input  logic [dnss_pkg::ZIDX_BITS-1:0]         zone_addr,
   output dnss_pkg::dp_sts_type                   sts,
   output logic                                   found,
   output logic [dnss_pkg::SIDX_BITS-1:0]         best
);
   import dnss_pkg::*;

   logic signed [COORD_BITS-1:0] sx_mem [MAX_SITES];
   logic signed [COORD_BITS-1:0] sy_mem [MAX_SITES];
   logic signed [COORD_BITS-1:0] zlx_ff [MAX_ZONES];
   logic signed [COORD_BITS-1:0] zhx_ff [MAX_ZONES];
   logic signed [COORD_BITS-1:0] zly_ff [MAX_ZONES];
   logic signed [COORD_BITS-1:0] zhy_ff [MAX_ZONES];

   logic signed [COORD_BITS-1:0] px_ff, py_ff, sx_ff, sy_ff;
   logic [2:0]                   dir_ff;
   logic                         strict_ff, same_ff;
   logic [ZIDX_BITS-1:0]         pzone_ff;
   logic                         pzhit_ff, szhit_ff, szfound_ff;
   logic [SIDX_BITS-1:0]         sidx_ff;
   logic                         found_ff;
   logic [SIDX_BITS-1:0]         best_ff;
   logic [SQ_BITS-1:0]           bdist_ff;

   logic                         xl, xg, yl, yg, ok, take;
   logic [DIFF_BITS-1:0]         sxe, pxe, sye, pye, dx, dy;
   logic [2*DIFF_BITS-1:0]       dx2, dy2;
   logic [SQ_BITS-1:0]           sq_dist;

   always_ff @(posedge clock) begin
      if (site_we) begin
         sx_mem[wr_site] <= in_x;
         sy_mem[wr_site] <= in_y;
      end
      if (cmd.site_read) begin
         sx_ff   <= sx_mem[site_addr];
         sy_ff   <= sy_mem[site_addr];
         sidx_ff <= site_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (zone_we) begin
         zlx_ff[wr_zone] <= in_x;
         zly_ff[wr_zone] <= in_y;
         zhx_ff[wr_zone] <= in_bx;
         zhy_ff[wr_zone] <= in_by;
      end
   end

   // Zone test is shared between the point search and the per-site check.
   logic signed [COORD_BITS-1:0] tx, ty;
   logic                         zin;
   assign tx  = cmd.szone_step ? sx_ff : px_ff;
   assign ty  = cmd.szone_step ? sy_ff : py_ff;
   assign zin = tx >= zlx_ff[zone_addr] && tx <= zhx_ff[zone_addr] &&
                ty >= zly_ff[zone_addr] && ty <= zhy_ff[zone_addr];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         px_ff     <= in_x;
         py_ff     <= in_y;
         dir_ff    <= in_dir;
         strict_ff <= in_strict;
         same_ff   <= in_same;
         pzhit_ff  <= 1'b0;
         found_ff  <= 1'b0;
      end else if (cmd.zone_step && zin && !pzhit_ff) begin
         pzhit_ff <= 1'b1;
         pzone_ff <= zone_addr;
      end
      if (cmd.clear) begin
         szfound_ff <= 1'b0;
         szhit_ff   <= 1'b0;
      end else if (cmd.szone_step && zin && !szfound_ff) begin
         szfound_ff <= 1'b1;
         szhit_ff   <= zone_addr == pzone_ff;
      end
      if (cmd.site_eval && take) begin
         found_ff <= 1'b1;
         best_ff  <= sidx_ff;
         bdist_ff <= sq_dist;
      end
   end

   always_comb begin
      xl = strict_ff ? sx_ff < px_ff : sx_ff <= px_ff;
      xg = strict_ff ? sx_ff > px_ff : sx_ff >= px_ff;
      yl = strict_ff ? sy_ff < py_ff : sy_ff <= py_ff;
      yg = strict_ff ? sy_ff > py_ff : sy_ff >= py_ff;
      unique case (dir_ff)
         DIR_LEFT:     ok = sy_ff == py_ff && xl;
         DIR_RIGHT:    ok = sy_ff == py_ff && xg;
         DIR_UP:       ok = sx_ff == px_ff && yl;
         DIR_DOWN:     ok = sx_ff == px_ff && yg;
         DIR_UPRIGHT:  ok = xg && yl;
         DIR_UPLEFT:   ok = xl && yl;
         DIR_DOWNLEFT: ok = xl && yg;
         default:      ok = xg && yg;
      endcase
      sxe = {sx_ff[COORD_BITS-1], sx_ff};
      pxe = {px_ff[COORD_BITS-1], px_ff};
      sye = {sy_ff[COORD_BITS-1], sy_ff};
      pye = {py_ff[COORD_BITS-1], py_ff};
      dx  = (sx_ff >= px_ff) ? sxe - pxe : pxe - sxe;
      dy  = (sy_ff >= py_ff) ? sye - pye : pye - sye;
      dx2 = {{DIFF_BITS{1'b0}}, dx} * {{DIFF_BITS{1'b0}}, dx};
      dy2 = {{DIFF_BITS{1'b0}}, dy} * {{DIFF_BITS{1'b0}}, dy};
      sq_dist = {1'b0, dx2} + {1'b0, dy2};
      take = 1'b0;
      if (ok && (!same_ff || szhit_ff)) begin
         priority if (dir_ff == DIR_LEFT || dir_ff == DIR_UP) take = 1'b1;
         else if (dir_ff == DIR_RIGHT || dir_ff == DIR_DOWN) take = !found_ff;
         else take = !found_ff || sq_dist < bdist_ff;
      end
   end

   assign sts.pt_zone_hit   = pzhit_ff;
   assign sts.site_zone_hit = szfound_ff;
   assign sts.same_zone     = same_ff;
   assign found = found_ff;
   assign best  = best_ff;
endmodule

[src/dnss_ctrl.sv]
// Controller: sequences the zone search and the site scan for one query.
// Depends on dnss_pkg; commands dnss_datapath.
module dnss_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [dnss_pkg::SCNT_BITS-1:0] site_count,
   input  logic [dnss_pkg::ZCNT_BITS-1:0] zone_count,
   input  dnss_pkg::dp_sts_type           sts,
   input  logic                           rsp_taken,
   output dnss_pkg::dp_cmd_type           cmd,
   output logic [dnss_pkg::SIDX_BITS-1:0] site_addr,
   output logic [dnss_pkg::ZIDX_BITS-1:0] zone_addr,
   output logic                           busy,
   output logic                           done,
   output logic                           no_zone
);
   import dnss_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PZONE = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_SZONE = 3'd3;
   localparam logic [2:0] S_EVAL  = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic [SCNT_BITS-1:0] site_ff, site_in, nsite;
   logic [ZCNT_BITS-1:0] zone_ff, zone_in, nzone;
   logic                 nz_ff, nz_in;

   assign nsite = (site_count > SCNT_BITS'(MAX_SITES)) ? SCNT_BITS'(MAX_SITES) : site_count;
   assign nzone = (zone_count > ZCNT_BITS'(MAX_ZONES)) ? ZCNT_BITS'(MAX_ZONES) : zone_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         site_ff  <= '0;
         zone_ff  <= '0;
         nz_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         site_ff  <= site_in;
         zone_ff  <= zone_in;
         nz_ff    <= nz_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      site_in  = site_ff;
      zone_in  = zone_ff;
      nz_in    = nz_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: if (start) begin
            cmd.capture = 1'b1;
            zone_in     = '0;
            state_in    = S_PZONE;
         end
         S_PZONE: begin
            // One zone per cycle; the hit flag is registered, so it lands in the cycle after its test.
            if (sts.pt_zone_hit) begin
               site_in  = '0;
               state_in = S_READ;
            end else if (zone_ff >= nzone) begin
               nz_in    = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.zone_step = 1'b1;
               zone_in       = zone_ff + 1'b1;
            end
         end
         S_READ: begin
            nz_in = 1'b0;
            if (site_ff >= nsite) state_in = S_DONE;
            else begin
               cmd.site_read = 1'b1;
               cmd.clear     = 1'b1;
               zone_in       = '0;
               state_in      = sts.same_zone ? S_SZONE : S_EVAL;
            end
         end
         S_SZONE: begin
            if (sts.site_zone_hit || zone_ff >= nzone) state_in = S_EVAL;
            else begin
               cmd.szone_step = 1'b1;
               zone_in        = zone_ff + 1'b1;
            end
         end
         S_EVAL: begin
            cmd.site_eval = 1'b1;
            site_in       = site_ff + 1'b1;
            state_in      = S_READ;
         end
         S_DONE: if (rsp_taken) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign site_addr = site_ff[SIDX_BITS-1:0];
   assign zone_addr = zone_ff[ZIDX_BITS-1:0];
   assign busy      = state_ff != S_IDLE;
   assign done      = state_ff == S_DONE;
   assign no_zone   = nz_ff;
endmodule
